@@ design/sst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, token kind codes and character tables for the source tokenizer.
package sst_pkg;

   localparam int POS_BITS = 24;
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

   typedef logic [5:0] kind_type;
   typedef logic [POS_BITS-1:0] pos_type;

   localparam kind_type K_NUM    = 6'd0;
   localparam kind_type K_ID     = 6'd1;
   localparam kind_type K_AND    = 6'd2;
   localparam kind_type K_OR     = 6'd3;
   localparam kind_type K_STR    = 6'd4;
   localparam kind_type K_LPAREN = 6'd5;
   localparam kind_type K_RPAREN = 6'd6;
   localparam kind_type K_LBRACK = 6'd7;
   localparam kind_type K_RBRACK = 6'd8;
   localparam kind_type K_LBRACE = 6'd9;
   localparam kind_type K_RBRACE = 6'd10;
   localparam kind_type K_SEMI   = 6'd11;
   localparam kind_type K_COLON  = 6'd12;
   localparam kind_type K_COMMA  = 6'd13;
   localparam kind_type K_BANG   = 6'd14;
   localparam kind_type K_ASSIGN = 6'd16;
   localparam kind_type K_PLUS   = 6'd18;
   localparam kind_type K_INC    = 6'd20;
   localparam kind_type K_MINUS  = 6'd21;
   localparam kind_type K_DEC    = 6'd23;
   localparam kind_type K_DOT    = 6'd24;
   localparam kind_type K_BAR    = 6'd25;
   localparam kind_type K_SLASH  = 6'd27;
   localparam kind_type K_LT     = 6'd29;
   localparam kind_type K_GT     = 6'd30;
   localparam kind_type K_CARET  = 6'd31;
   localparam kind_type K_STAR   = 6'd32;
   localparam kind_type K_AMP    = 6'd34;
   localparam kind_type K_PCT    = 6'd36;
   localparam kind_type K_HASH   = 6'd37;
   localparam kind_type K_EOF    = 6'd38;
   localparam kind_type K_ERR    = 6'd39;

   // keyword prefix tracker codes
   localparam logic [3:0] KW_NONE  = 4'd0;
   localparam logic [3:0] KW_T     = 4'd1;
   localparam logic [3:0] KW_TR    = 4'd2;
   localparam logic [3:0] KW_TRU   = 4'd3;
   localparam logic [3:0] KW_TRUE  = 4'd4;
   localparam logic [3:0] KW_F     = 4'd5;
   localparam logic [3:0] KW_FA    = 4'd6;
   localparam logic [3:0] KW_FAL   = 4'd7;
   localparam logic [3:0] KW_FALS  = 4'd8;
   localparam logic [3:0] KW_FALSE = 4'd9;
   localparam logic [3:0] KW_A     = 4'd10;
   localparam logic [3:0] KW_AN    = 4'd11;
   localparam logic [3:0] KW_AND   = 4'd12;
   localparam logic [3:0] KW_O     = 4'd13;
   localparam logic [3:0] KW_OR    = 4'd14;

   typedef struct packed {
      logic     is_space;
      logic     is_digit;
      logic     is_letter;
      logic     is_quote;
      logic     is_zero;
      logic     can_merge;
      kind_type single;   // zero when not a one-byte operator
   } cls_type;

   typedef struct packed {
      logic [7:0] ch;
      cls_type    cls;
      pos_type    offset;
   } fq_entry_type;

   typedef struct packed {
      logic         valid;
      fq_entry_type entry;
   } fq_head_type;

   typedef struct packed {
      kind_type kind;
      pos_type  start;
      pos_type  length;
      logic     is_bool;
      logic     bool_val;
      logic     last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } tok_push_type;

   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         "[": k = K_LBRACK;
         "]": k = K_RBRACK;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         ";": k = K_SEMI;
         ":": k = K_COLON;
         ",": k = K_COMMA;
         "!": k = K_BANG;
         "=": k = K_ASSIGN;
         "+": k = K_PLUS;
         "-": k = K_MINUS;
         ".": k = K_DOT;
         "|": k = K_BAR;
         "/": k = K_SLASH;
         "<": k = K_LT;
         ">": k = K_GT;
         "^": k = K_CARET;
         "*": k = K_STAR;
         "&": k = K_AMP;
         "%": k = K_PCT;
         "#": k = K_HASH;
         default: k = K_NUM;
      endcase
      return k;
   endfunction

   function automatic cls_type classify(input logic [7:0] c);
      cls_type r;
      r.is_space  = (c == " ") || (c == 8'h09) || (c == 8'h0a);
      r.is_digit  = (c >= "0") && (c <= "9");
      r.is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
      r.is_quote  = (c == 8'h22) || (c == 8'h27);
      r.is_zero   = (c == 8'h00);
      r.can_merge = (c == "!") || (c == "=") || (c == "+") || (c == "-") ||
                    (c == "|") || (c == "/") || (c == "*") || (c == "&");
      r.single    = single_kind(c);
      return r;
   endfunction

   // expected next byte of a keyword prefix, zero when none
   function automatic logic [7:0] kw_want(input logic [3:0] m);
      logic [7:0] w;
      case (m)
         KW_T:    w = "r";
         KW_TR:   w = "u";
         KW_TRU:  w = "e";
         KW_F:    w = "a";
         KW_FA:   w = "l";
         KW_FAL:  w = "s";
         KW_FALS: w = "e";
         KW_A:    w = "n";
         KW_AN:   w = "d";
         KW_O:    w = "r";
         default: w = 8'h00;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] kw_start(input logic [7:0] c);
      logic [3:0] m;
      case (c)
         "t": m = KW_T;
         "f": m = KW_F;
         "a": m = KW_A;
         "o": m = KW_O;
         default: m = KW_NONE;
      endcase
      return m;
   endfunction

endpackage

@@ design/script_source_tokenizer.sv @@
`timescale 1ns / 1ps
// Top level of the source tokenizer: front end, scanner and result queue.
//
// Source bytes enter on req_source_byte; a request is taken at a clock edge
// with req_push high and req_full low. Tokens leave through a queue: while
// rsp_empty is low the oldest token sits on the rsp_ ports, and rsp_pop
// takes it. A zero byte yields an end-of-file token; an undefined byte (or
// a zero inside a string) yields an error token and every later byte then
// yields one error token until reset.
// A token is known once the byte that ends it has been scanned: it enters the
// result queue at the edge that takes that byte from the byte queue. One byte
// may give two tokens; rsp_last_of_run marks the last token from each byte.
// Throughput is one byte per cycle, set by the single-step scanner, which
// takes a byte only while the four-entry result queue has room for two
// tokens. When the receiver stalls the result queue fills, the scanner
// stops and the four-entry byte queue fills until req_full rises.
// Reset (synchronous, active high) empties both queues, restarts offsets at
// zero and clears the scanner and the sticky error.
module script_source_tokenizer import sst_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_source_byte,
   input  logic                req_push,
   output logic                req_full,
   output logic [5:0]          rsp_token_kind,
   output logic [POS_BITS-1:0] rsp_token_start,
   output logic [POS_BITS-1:0] rsp_token_length,
   output logic                rsp_is_bool_literal,
   output logic                rsp_bool_value,
   output logic                rsp_last_of_run,
   output logic                rsp_empty,
   input  logic                rsp_pop
);

   fq_head_type       fq_head;
   logic              take;
   logic              room;
   tok_push_type      push;
   token_type         oq_head;
   logic [OQ_PTR_W:0] oq_level;

   sst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_source_byte (req_source_byte),
      .req_push        (req_push),
      .req_full        (req_full),
      .take            (take),
      .head            (fq_head)
   );

   sst_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (fq_head),
      .room  (room),
      .take  (take),
      .push  (push)
   );

   sst_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .level     (oq_level),
      .head      (oq_head),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_token_kind      = oq_head.kind;
   assign rsp_token_start     = oq_head.start;
   assign rsp_token_length    = oq_head.length;
   assign rsp_is_bool_literal = oq_head.is_bool;
   assign rsp_bool_value      = oq_head.bool_val;
   assign rsp_last_of_run     = oq_head.last;

   // scanner only steps on a queued byte
   assert property (@(posedge clock) disable iff (reset) take |-> fq_head.valid)
      else $error("scanner took a byte from an empty queue");

   // result queue never overflows
   assert property (@(posedge clock) disable iff (reset)
      oq_level <= (OQ_PTR_W+1)'(OQ_DEPTH))
      else $error("result queue overflow");

   // a step that pushes two tokens flags only the second one as last
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.tok0.last && push.tok1.last))
      else $error("last_of_run misplaced on a two-token step");

   // reset leaves both queues empty
   assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

@@ design/sst_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts source bytes, classifies them, tags offsets and queues them.
module sst_front import sst_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_source_byte,
   input  logic        req_push,
   output logic        req_full,
   input  logic        take,
   output fq_head_type head
);

   fq_entry_type         mem_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]  wr_ff, wr_in;
   logic [FQ_PTR_W-1:0]  rd_ff, rd_in;
   logic [FQ_PTR_W:0]    count_ff, count_in;
   pos_type              offset_ff, offset_in;
   logic                 accept;
   logic                 pop;

   assign req_full = (count_ff == (FQ_PTR_W+1)'(FQ_DEPTH));
   assign accept   = req_push && !req_full;
   assign pop      = take && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ff];

   always_comb begin
      wr_in     = accept ? wr_ff + 1'b1 : wr_ff;
      rd_in     = pop ? rd_ff + 1'b1 : rd_ff;
      offset_in = accept ? offset_ff + 1'b1 : offset_ff;
      count_in  = count_ff + (FQ_PTR_W+1)'(accept) - (FQ_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff     <= '0;
         rd_ff     <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
      end else begin
         wr_ff     <= wr_in;
         rd_ff     <= rd_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_ff[wr_ff].ch     <= req_source_byte;
         mem_ff[wr_ff].cls    <= classify(req_source_byte);
         mem_ff[wr_ff].offset <= offset_ff;
      end
   end

endmodule

@@ design/sst_back.sv @@
`timescale 1ns / 1ps
// Back end: scanner state machine that turns classified bytes into tokens.
module sst_back import sst_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  fq_head_type  head,
   input  logic         room,
   output logic         take,
   output tok_push_type push
);

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_NUM  = 5'b00010,
      MODE_ID   = 5'b00100,
      MODE_STR  = 5'b01000,
      MODE_OP   = 5'b10000
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] quote_ff, quote_in;
   pos_type    origin_ff, origin_in;
   pos_type    run_ff, run_in;
   logic [3:0] kw_ff, kw_in;
   logic       err_ff, err_in;

   logic [7:0] c;
   cls_type    cl;
   pos_type    pos;
   pos_type    run_grown;
   logic       do_start;
   token_type  t0, t1, st_tok, blank;
   logic [1:0] n;
   logic       st_has;

   assign take = head.valid && room;
   assign c    = head.entry.ch;
   assign cl   = head.entry.cls;
   assign pos  = head.entry.offset;
   assign run_grown = (run_ff == '1) ? run_ff : run_ff + 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      quote_in  = quote_ff;
      origin_in = origin_ff;
      run_in    = run_ff;
      kw_in     = kw_ff;
      err_in    = err_ff;
      blank     = '0;
      t0        = '0;
      t1        = '0;
      st_tok    = '0;
      st_has    = 1'b0;
      n         = 2'd0;
      do_start  = 1'b0;

      if (err_ff) begin
         t0      = blank;
         t0.kind = K_ERR;
         t0.start = origin_ff;
         n       = 2'd1;
      end else begin
         case (mode_ff)
            MODE_NUM: begin
               if (cl.is_digit) begin
                  run_in = run_grown;
               end else begin
                  t0.kind   = K_NUM;
                  t0.start  = origin_ff;
                  t0.length = run_ff;
                  n         = 2'd1;
                  do_start  = 1'b1;
               end
            end
            MODE_ID: begin
               if (cl.is_digit || cl.is_letter) begin
                  run_in = run_grown;
                  kw_in  = (kw_want(kw_ff) != 8'h00 && kw_want(kw_ff) == c) ?
                           kw_ff + 1'b1 : KW_NONE;
               end else begin
                  t0.start  = origin_ff;
                  t0.length = run_ff;
                  case (kw_ff)
                     KW_TRUE: begin
                        t0.kind     = K_NUM;
                        t0.is_bool  = 1'b1;
                        t0.bool_val = 1'b1;
                     end
                     KW_FALSE: begin
                        t0.kind    = K_NUM;
                        t0.is_bool = 1'b1;
                     end
                     KW_AND:  t0.kind = K_AND;
                     KW_OR:   t0.kind = K_OR;
                     default: t0.kind = K_ID;
                  endcase
                  n        = 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_STR: begin
               if (c == quote_ff) begin
                  t0.kind   = K_STR;
                  t0.start  = origin_ff;
                  t0.length = run_ff;
                  n         = 2'd1;
                  mode_in   = MODE_IDLE;
               end else if (cl.is_zero) begin
                  err_in    = 1'b1;
                  origin_in = pos;
                  mode_in   = MODE_IDLE;
                  t0.kind   = K_ERR;
                  t0.start  = pos;
                  n         = 2'd1;
               end else begin
                  run_in = run_grown;
               end
            end
            MODE_OP: begin
               t0.start = origin_ff;
               n        = 2'd1;
               if (c == "=") begin
                  t0.kind   = single_kind(held_ff) + 1'b1;
                  t0.length = pos_type'(2);
                  mode_in   = MODE_IDLE;
               end else if (held_ff == "+" && c == "+") begin
                  t0.kind   = K_INC;
                  t0.length = pos_type'(2);
                  mode_in   = MODE_IDLE;
               end else if (held_ff == "-" && c == "-") begin
                  t0.kind   = K_DEC;
                  t0.length = pos_type'(2);
                  mode_in   = MODE_IDLE;
               end else begin
                  t0.kind   = single_kind(held_ff);
                  t0.length = pos_type'(1);
                  do_start  = 1'b1;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase

         // byte scanned as the beginning of a new token
         if (do_start) begin
            mode_in = MODE_IDLE;
            if (cl.is_space) begin
               mode_in = MODE_IDLE;
            end else if (cl.is_digit) begin
               mode_in   = MODE_NUM;
               origin_in = pos;
               run_in    = pos_type'(1);
            end else if (cl.is_letter) begin
               mode_in   = MODE_ID;
               origin_in = pos;
               run_in    = pos_type'(1);
               kw_in     = kw_start(c);
            end else if (cl.is_quote) begin
               mode_in   = MODE_STR;
               quote_in  = c;
               origin_in = pos;
               run_in    = '0;
            end else if (cl.is_zero) begin
               st_has       = 1'b1;
               st_tok.kind  = K_EOF;
               st_tok.start = pos;
            end else if (cl.can_merge) begin
               mode_in   = MODE_OP;
               held_in   = c;
               origin_in = pos;
            end else if (cl.single != K_NUM) begin
               st_has        = 1'b1;
               st_tok.kind   = cl.single;
               st_tok.start  = pos;
               st_tok.length = pos_type'(1);
            end else begin
               err_in       = 1'b1;
               origin_in    = pos;
               st_has       = 1'b1;
               st_tok.kind  = K_ERR;
               st_tok.start = pos;
            end
            if (st_has) begin
               if (n == 2'd0) begin
                  t0 = st_tok;
                  n  = 2'd1;
               end else begin
                  t1 = st_tok;
                  n  = 2'd2;
               end
            end
         end
      end

      if (n == 2'd1) begin
         t0.last = 1'b1;
      end
      if (n == 2'd2) begin
         t1.last = 1'b1;
      end
      if (!take) begin
         n = 2'd0;
      end
      push.count = n;
      push.tok0  = t0;
      push.tok1  = t1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         held_ff   <= '0;
         quote_ff  <= '0;
         origin_ff <= '0;
         run_ff    <= '0;
         kw_ff     <= KW_NONE;
         err_ff    <= 1'b0;
      end else if (take) begin
         mode_ff   <= mode_in;
         held_ff   <= held_in;
         quote_ff  <= quote_in;
         origin_ff <= origin_in;
         run_ff    <= run_in;
         kw_ff     <= kw_in;
         err_ff    <= err_in;
      end
   end

endmodule

@@ design/sst_out_queue.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to two tokens per cycle, hands out one per pop.
module sst_out_queue import sst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  tok_push_type  push,
   output logic          room,
   output logic [OQ_PTR_W:0] level,
   output token_type     head,
   output logic          rsp_empty,
   input  logic          rsp_pop
);

   token_type            mem_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]  wr_ff, wr_in;
   logic [OQ_PTR_W-1:0]  rd_ff, rd_in;
   logic [OQ_PTR_W:0]    count_ff, count_in;
   logic [OQ_PTR_W-1:0]  wr_next;
   logic                 pop;

   assign rsp_empty = (count_ff == '0);
   assign pop       = rsp_pop && !rsp_empty;
   assign room      = (count_ff <= (OQ_PTR_W+1)'(OQ_DEPTH - 2));
   assign level     = count_ff;
   assign head      = mem_ff[rd_ff];
   assign wr_next   = wr_ff + 1'b1;

   always_comb begin
      wr_in    = wr_ff + OQ_PTR_W'(push.count);
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (OQ_PTR_W+1)'(push.count) - (OQ_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.tok1;
      end
   end

endmodule
